FILE: hdl/ptt_pkg.sv
// shared types and constants of the periodic timer table
package ptt_pkg;

    localparam int TICK_W      = 32;
    localparam int ENTRY_W     = 2 * TICK_W;
    localparam int OP_W        = 3;
    localparam int ID_W        = 3;
    localparam int SLOT_W      = 3;
    localparam int MAX_REPORTS = 8;
    localparam int CNT_W       = $clog2(MAX_REPORTS + 1);

    localparam logic [TICK_W-1:0] TICK_MAX = 32'hFFFF_FFFF;

    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_START = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd5;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_EXPIRY = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [TICK_W-1:0]  time_left;
        logic               running;
        logic               last;
    } resp_t;

endpackage

FILE: hdl/ptt_mem.sv
// timer entry memory: {period, remaining} per slot, one write and one registered read port
module ptt_mem #(
    parameter int NUM_TIMERS = 8,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [ptt_pkg::ENTRY_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [ptt_pkg::ENTRY_W-1:0]  rd_data
);

    logic [ptt_pkg::ENTRY_W-1:0] mem [NUM_TIMERS];
    logic [ptt_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ptt_out.sv
// result output register with valid/stall handshake
module ptt_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    input  ptt_pkg::resp_t              push_data,
    output logic                        free,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [1:0]                  result_kind,
    output logic [ptt_pkg::SLOT_W-1:0]  slot,
    output logic [ptt_pkg::TICK_W-1:0]  time_left,
    output logic                        running,
    output logic                        last
);

    logic           valid_reg;
    logic           valid_next;
    ptt_pkg::resp_t data_reg;

    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_valid && free)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && free)
        begin
            data_reg <= push_data;
        end
    end

    assign rsp_valid   = valid_reg;
    assign result_kind = data_reg.kind;
    assign slot        = data_reg.slot;
    assign time_left   = data_reg.time_left;
    assign running     = data_reg.running;
    assign last        = data_reg.last;

endmodule

FILE: hdl/ptt_ctrl.sv
// command sequencer: decodes transactions, walks the timer memory, forms results
module ptt_ctrl #(
    parameter int NUM_TIMERS = 8,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [ptt_pkg::OP_W-1:0]     operation,
    input  logic [ptt_pkg::ID_W-1:0]     timer_id,
    input  logic [ptt_pkg::TICK_W-1:0]   unit_ticks,
    input  logic [ptt_pkg::TICK_W-1:0]   duration,
    input  logic [ptt_pkg::TICK_W-1:0]   tick_now,
    output logic                         mem_wr_en,
    output logic [IDX_W-1:0]             mem_wr_addr,
    output logic [ptt_pkg::ENTRY_W-1:0]  mem_wr_data,
    output logic                         mem_rd_en,
    output logic [IDX_W-1:0]             mem_rd_addr,
    input  logic [ptt_pkg::ENTRY_W-1:0]  mem_rd_data,
    output logic                         push_valid,
    output ptt_pkg::resp_t               push_data,
    input  logic                         out_free
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_START    = 9'b000000100,
        S_ALLOC    = 9'b000001000,
        S_QREAD    = 9'b000010000,
        S_SCAN_RD  = 9'b000100000,
        S_SCAN_EV  = 9'b001000000,
        S_SCAN_END = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [ptt_pkg::OP_W-1:0]       op_reg;
    logic [ptt_pkg::ID_W-1:0]       id_reg;
    logic [ptt_pkg::TICK_W-1:0]     unit_reg;
    logic [ptt_pkg::TICK_W-1:0]     dur_reg;
    logic [ptt_pkg::TICK_W-1:0]     now_reg;
    logic [ptt_pkg::ENTRY_W-1:0]    prod_reg;
    logic [NUM_TIMERS-1:0]          used_reg, used_next;
    logic [NUM_TIMERS-1:0]          run_reg, run_next;
    logic                           base_valid_reg, base_valid_next;
    logic [ptt_pkg::TICK_W-1:0]     prev_tick_reg, prev_tick_next;
    logic [ptt_pkg::TICK_W-1:0]     elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [ptt_pkg::CNT_W-1:0]      n_reg, n_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]               pend_slot_reg, pend_slot_next;
    ptt_pkg::resp_t                 resp_reg, resp_next;

    logic                           cmd_accept;
    logic                           in_range;
    logic [IDX_W-1:0]               id_idx;
    logic                           idx_last;
    logic [ptt_pkg::TICK_W-1:0]     period_sat;
    logic [ptt_pkg::TICK_W-1:0]     rd_period;
    logic [ptt_pkg::TICK_W-1:0]     rd_remain;
    logic [ptt_pkg::TICK_W-1:0]     remain_sub;
    logic [ptt_pkg::TICK_W-1:0]     remain_new;
    logic                           expire;
    logic                           report;
    logic                           ev_blocked;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && (state_reg == S_IDLE);

    assign in_range = (32'(id_reg) < 32'(NUM_TIMERS));
    assign id_idx   = IDX_W'(id_reg);
    assign idx_last = (idx_reg == IDX_W'(NUM_TIMERS - 1));

    // saturate the registered 64-bit product to 32 bits
    assign period_sat = (|prod_reg[ptt_pkg::ENTRY_W-1:ptt_pkg::TICK_W]) ?
                        ptt_pkg::TICK_MAX : prod_reg[ptt_pkg::TICK_W-1:0];

    assign rd_period  = mem_rd_data[ptt_pkg::ENTRY_W-1:ptt_pkg::TICK_W];
    assign rd_remain  = mem_rd_data[ptt_pkg::TICK_W-1:0];
    assign remain_sub = rd_remain - elapsed_reg;
    assign remain_new = (rd_remain >= elapsed_reg) ? remain_sub : '0;
    assign expire     = (remain_new == '0);
    assign report     = expire && (n_reg < ptt_pkg::CNT_W'(ptt_pkg::MAX_REPORTS));
    // a new expiry pushes the held one out first, so the output must have room
    assign ev_blocked = report && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        run_next        = run_reg;
        base_valid_next = base_valid_reg;
        prev_tick_next  = prev_tick_reg;
        elapsed_next    = elapsed_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        resp_next       = resp_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = id_idx;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = id_idx;
        push_valid      = 1'b0;
        push_data       = resp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                resp_next  = '{kind: ptt_pkg::KIND_DONE, slot: '0, time_left: '0,
                               running: 1'b0, last: 1'b1};
                case (op_reg)
                    ptt_pkg::OP_ALLOC:
                    begin
                        idx_next   = '0;
                        state_next = S_ALLOC;
                    end
                    ptt_pkg::OP_FREE:
                    begin
                        if (in_range)
                        begin
                            used_next[id_idx] = 1'b0;
                            run_next[id_idx]  = 1'b0;
                            mem_wr_en         = 1'b1;
                        end
                        else
                        begin
                            resp_next.kind = ptt_pkg::KIND_REJECT;
                        end
                    end
                    ptt_pkg::OP_START:
                    begin
                        if (in_range && used_reg[id_idx])
                        begin
                            state_next = S_START;
                        end
                        else
                        begin
                            resp_next.kind = ptt_pkg::KIND_REJECT;
                        end
                    end
                    ptt_pkg::OP_STOP:
                    begin
                        if (in_range)
                        begin
                            run_next[id_idx] = 1'b0;
                            mem_wr_en        = 1'b1;
                        end
                        else
                        begin
                            resp_next.kind = ptt_pkg::KIND_REJECT;
                        end
                    end
                    ptt_pkg::OP_QUERY:
                    begin
                        if (in_range)
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = S_QREAD;
                        end
                        else
                        begin
                            resp_next.kind = ptt_pkg::KIND_REJECT;
                        end
                    end
                    ptt_pkg::OP_TICK:
                    begin
                        prev_tick_next = now_reg;
                        if (!base_valid_reg)
                        begin
                            base_valid_next = 1'b1;
                        end
                        else
                        begin
                            elapsed_next    = now_reg - prev_tick_reg;
                            idx_next        = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        resp_next.kind = ptt_pkg::KIND_REJECT;
                    end
                endcase
            end

            S_START:
            begin
                mem_wr_en        = 1'b1;
                mem_wr_data      = {period_sat, period_sat};
                run_next[id_idx] = |period_sat;
                state_next       = S_RESP;
            end

            // lowest free slot, one slot per cycle
            S_ALLOC:
            begin
                if (!used_reg[idx_reg])
                begin
                    used_next[idx_reg] = 1'b1;
                    run_next[idx_reg]  = 1'b0;
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = idx_reg;
                    resp_next.slot     = ptt_pkg::SLOT_W'(idx_reg);
                    state_next         = S_RESP;
                end
                else if (idx_last)
                begin
                    resp_next.kind = ptt_pkg::KIND_REJECT;
                    state_next     = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_QREAD:
            begin
                resp_next.kind      = ptt_pkg::KIND_QUERY;
                resp_next.slot      = id_reg;
                resp_next.running   = run_reg[id_idx];
                resp_next.time_left = run_reg[id_idx] ? rd_remain : '0;
                state_next          = S_RESP;
            end

            S_SCAN_RD:
            begin
                if (run_reg[idx_reg])
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg;
                    state_next  = S_SCAN_EV;
                end
                else if (idx_last)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_SCAN_EV:
            begin
                if (!ev_blocked)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = idx_reg;
                    mem_wr_data = {rd_period, expire ? rd_period : remain_new};
                    if (report)
                    begin
                        // the held expiry is not the final one
                        if (pend_valid_reg)
                        begin
                            push_valid = 1'b1;
                            push_data  = '{kind: ptt_pkg::KIND_EXPIRY,
                                           slot: ptt_pkg::SLOT_W'(pend_slot_reg),
                                           time_left: '0, running: 1'b0, last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        n_next          = n_reg + 1'b1;
                    end
                    if (idx_last)
                    begin
                        state_next = S_SCAN_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_END:
            begin
                if (out_free)
                begin
                    push_valid = 1'b1;
                    if (pend_valid_reg)
                    begin
                        push_data = '{kind: ptt_pkg::KIND_EXPIRY,
                                      slot: ptt_pkg::SLOT_W'(pend_slot_reg),
                                      time_left: '0, running: 1'b0, last: 1'b1};
                    end
                    else
                    begin
                        push_data = '{kind: ptt_pkg::KIND_DONE, slot: '0, time_left: '0,
                                      running: 1'b0, last: 1'b1};
                    end
                    state_next = S_IDLE;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    push_valid = 1'b1;
                    push_data  = resp_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            run_reg        <= '0;
            base_valid_reg <= 1'b0;
            prev_tick_reg  <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            run_reg        <= run_next;
            base_valid_reg <= base_valid_next;
            prev_tick_reg  <= prev_tick_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            op_reg   <= operation;
            id_reg   <= timer_id;
            unit_reg <= unit_ticks;
            dur_reg  <= duration;
            now_reg  <= tick_now;
        end
        if (state_reg == S_EXEC)
        begin
            prod_reg <= ptt_pkg::ENTRY_W'(unit_reg) * ptt_pkg::ENTRY_W'(dur_reg);
        end
        elapsed_reg   <= elapsed_next;
        pend_slot_reg <= pend_slot_next;
        resp_reg      <= resp_next;
    end

endmodule

FILE: hdl/periodic_timer_table.sv
// top level of the periodic timer table
//
// Commands enter on the cmd channel (cmd_valid / cmd_stall) with fields
// operation, timer_id, unit_ticks, duration and tick_now. Results leave on
// the rsp channel (rsp_valid / rsp_stall); the final result of a command has
// last set. One command is handled at a time: cmd_stall is high from the
// cycle after a transaction until its final result is in the output register.
// From command transaction to result on rsp: free, stop and rejects go
// straight from S_EXEC to the response; start adds a multiplier stage and
// query a memory read; allocate searches upward from the lowest slot. A
// tick walks the timer memory one slot per cycle; a running slot also gets
// a read-modify-write in S_SCAN_EV, which can wait there on the output.
// After reset all slots are free, no timer runs and the first tick only
// records its baseline; the memory needs no clearing pass since a slot's
// entry is written on allocation. A stalled result stays in the output
// register; further expiries of a tick then wait in place until it drains.
module periodic_timer_table #(
    parameter int NUM_TIMERS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_stall,
    input  logic [2:0]   operation,
    input  logic [2:0]   timer_id,
    input  logic [31:0]  unit_ticks,
    input  logic [31:0]  duration,
    input  logic [31:0]  tick_now,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output logic [1:0]   result_kind,
    output logic [2:0]   slot,
    output logic [31:0]  time_left,
    output logic         running,
    output logic         last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic                         mem_wr_en;
    logic [IDX_W-1:0]             mem_wr_addr;
    logic [ptt_pkg::ENTRY_W-1:0]  mem_wr_data;
    logic                         mem_rd_en;
    logic [IDX_W-1:0]             mem_rd_addr;
    logic [ptt_pkg::ENTRY_W-1:0]  mem_rd_data;
    logic                         push_valid;
    ptt_pkg::resp_t               push_data;
    logic                         out_free;

    ptt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .operation   (operation),
        .timer_id    (timer_id),
        .unit_ticks  (unit_ticks),
        .duration    (duration),
        .tick_now    (tick_now),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .out_free    (out_free)
    );

    ptt_mem #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ptt_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .free        (out_free),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_kind (result_kind),
        .slot        (slot),
        .time_left   (time_left),
        .running     (running),
        .last        (last)
    );

endmodule

FILE: sim/tb_periodic_timer_table.sv
// self-checking testbench for the periodic timer table
`timescale 1ns / 100ps

module tb_periodic_timer_table;

    localparam int NTIMERS        = 8;
    localparam int ITEM_TARGET    = 370;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        bit                         drain;
        logic [ptt_pkg::OP_W-1:0]   op;
        logic [ptt_pkg::ID_W-1:0]   id;
        logic [ptt_pkg::TICK_W-1:0] ticks_per_unit;
        logic [ptt_pkg::TICK_W-1:0] units;
        logic [ptt_pkg::TICK_W-1:0] now_val;
    } cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    logic [2:0]        operation = '0;
    logic [2:0]        timer_id = '0;
    logic [31:0]       unit_ticks = '0;
    logic [31:0]       duration = '0;
    logic [31:0]       tick_now = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [1:0]        result_kind;
    logic [2:0]        slot;
    logic [31:0]       time_left;
    logic              running;
    logic              last;

    cmd_t              pending_cmds[$];
    ptt_pkg::resp_t    expected_rsps[$];
    int                errors = 0;

    // predicted timer table
    bit                         tbl_used[NTIMERS];
    logic [ptt_pkg::TICK_W-1:0] tbl_period[NTIMERS];
    logic [ptt_pkg::TICK_W-1:0] tbl_left[NTIMERS];
    logic [ptt_pkg::TICK_W-1:0] last_tick = '0;
    bit                         have_baseline = 1'b0;

    // stimulus-side view of slot allocation
    bit                         gen_used[NTIMERS];
    logic [ptt_pkg::TICK_W-1:0] gen_now = '0;
    int                         n_items = 0;

    periodic_timer_table #(.NUM_TIMERS(NTIMERS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .operation   (operation),
        .timer_id    (timer_id),
        .unit_ticks  (unit_ticks),
        .duration    (duration),
        .tick_now    (tick_now),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_kind (result_kind),
        .slot        (slot),
        .time_left   (time_left),
        .running     (running),
        .last        (last)
    );

    always #5 clk = ~clk;

    task automatic predict_results(input cmd_t c);
        ptt_pkg::resp_t             r;
        ptt_pkg::resp_t             expiries[ptt_pkg::MAX_REPORTS];
        logic [ptt_pkg::TICK_W-1:0] elapsed;
        logic [63:0]                prod;
        bit                         found;
        int                         n;
        r = '0;
        r.kind = ptt_pkg::KIND_REJECT;
        r.last = 1'b1;
        found = 1'b0;
        n = 0;
        case (c.op)
            ptt_pkg::OP_ALLOC:
            begin
                for (int i = 0; i < NTIMERS; i++)
                begin
                    if (!found && !tbl_used[i])
                    begin
                        found = 1'b1;
                        tbl_used[i] = 1'b1;
                        tbl_period[i] = '0;
                        tbl_left[i] = '0;
                        r.kind = ptt_pkg::KIND_DONE;
                        r.slot = 3'(i);
                    end
                end
                expected_rsps.push_back(r);
            end
            ptt_pkg::OP_FREE:
            begin
                if (c.id < NTIMERS)
                begin
                    tbl_used[c.id] = 1'b0;
                    tbl_period[c.id] = '0;
                    tbl_left[c.id] = '0;
                    r.kind = ptt_pkg::KIND_DONE;
                end
                expected_rsps.push_back(r);
            end
            ptt_pkg::OP_START:
            begin
                if (c.id < NTIMERS && tbl_used[c.id])
                begin
                    prod = {32'd0, c.ticks_per_unit} * {32'd0, c.units};
                    if (prod > {32'd0, ptt_pkg::TICK_MAX})
                        prod = {32'd0, ptt_pkg::TICK_MAX};
                    tbl_period[c.id] = prod[ptt_pkg::TICK_W-1:0];
                    tbl_left[c.id] = prod[ptt_pkg::TICK_W-1:0];
                    r.kind = ptt_pkg::KIND_DONE;
                end
                expected_rsps.push_back(r);
            end
            ptt_pkg::OP_STOP:
            begin
                if (c.id < NTIMERS)
                begin
                    tbl_period[c.id] = '0;
                    tbl_left[c.id] = '0;
                    r.kind = ptt_pkg::KIND_DONE;
                end
                expected_rsps.push_back(r);
            end
            ptt_pkg::OP_QUERY:
            begin
                if (c.id < NTIMERS)
                begin
                    r.kind = ptt_pkg::KIND_QUERY;
                    r.slot = c.id;
                    if (tbl_used[c.id] && tbl_period[c.id] != 0)
                    begin
                        r.time_left = tbl_left[c.id];
                        r.running = 1'b1;
                    end
                end
                expected_rsps.push_back(r);
            end
            ptt_pkg::OP_TICK:
            begin
                r.kind = ptt_pkg::KIND_DONE;
                if (!have_baseline)
                begin
                    // first tick only sets the reference point
                    have_baseline = 1'b1;
                    last_tick = c.now_val;
                    expected_rsps.push_back(r);
                end
                else
                begin
                    elapsed = c.now_val - last_tick;
                    last_tick = c.now_val;
                    for (int i = 0; i < NTIMERS; i++)
                    begin
                        if (tbl_used[i] && tbl_period[i] != 0)
                        begin
                            tbl_left[i] = (tbl_left[i] >= elapsed) ?
                                          tbl_left[i] - elapsed : '0;
                            if (tbl_left[i] == 0)
                            begin
                                tbl_left[i] = tbl_period[i];
                                if (n < ptt_pkg::MAX_REPORTS)
                                begin
                                    expiries[n] = '0;
                                    expiries[n].kind = ptt_pkg::KIND_EXPIRY;
                                    expiries[n].slot = 3'(i);
                                    n++;
                                end
                            end
                        end
                    end
                    if (n == 0)
                        expected_rsps.push_back(r);
                    else
                    begin
                        expiries[n-1].last = 1'b1;
                        for (int k = 0; k < n; k++)
                            expected_rsps.push_back(expiries[k]);
                    end
                end
            end
            default:
                expected_rsps.push_back(r);
        endcase
    endtask

    task automatic add_cmd(input logic [ptt_pkg::OP_W-1:0] op,
                           input logic [ptt_pkg::ID_W-1:0] id,
                           input logic [ptt_pkg::TICK_W-1:0] tpu,
                           input logic [ptt_pkg::TICK_W-1:0] units,
                           input logic [ptt_pkg::TICK_W-1:0] now_val);
        cmd_t c;
        bit   done;
        c.drain = 1'b0;
        c.op = op;
        c.id = id;
        c.ticks_per_unit = tpu;
        c.units = units;
        c.now_val = now_val;
        pending_cmds.push_back(c);
        n_items++;
        done = 1'b0;
        if (op == ptt_pkg::OP_ALLOC)
        begin
            for (int i = 0; i < NTIMERS; i++)
            begin
                if (!done && !gen_used[i])
                begin
                    gen_used[i] = 1'b1;
                    done = 1'b1;
                end
            end
        end
        else if (op == ptt_pkg::OP_FREE)
            gen_used[id] = 1'b0;
        else if (op == ptt_pkg::OP_TICK)
            gen_now = now_val;
    endtask

    task automatic add_drain();
        cmd_t c;
        c = '{default: '0};
        c.drain = 1'b1;
        pending_cmds.push_back(c);
    endtask

    // mostly an allocated slot, sometimes any slot
    function automatic logic [ptt_pkg::ID_W-1:0] pick_slot();
        logic [ptt_pkg::ID_W-1:0] s;
        s = 3'($urandom_range(0, NTIMERS - 1));
        if ($urandom_range(0, 99) < 85)
        begin
            for (int tries = 0; tries < 16; tries++)
            begin
                if (!gen_used[s])
                    s = 3'($urandom_range(0, NTIMERS - 1));
            end
        end
        return s;
    endfunction

    // command driver: bursts with random gaps, paused at drain markers
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        cmd_t cur_cmd;
        int   burst_left;
        int   gap_left;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            operation <= '0;
            timer_id <= '0;
            unit_ticks <= '0;
            duration <= '0;
            tick_now <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                predict_results(cur_cmd);
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                    cmd_valid <= 1'b0;
                else if (pending_cmds[0].drain)
                begin
                    cmd_valid <= 1'b0;
                    if (expected_rsps.size() == 0)
                        void'(pending_cmds.pop_front());
                end
                else
                begin
                    cur_cmd = pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    operation <= cur_cmd.op;
                    timer_id <= cur_cmd.id;
                    unit_ticks <= cur_cmd.ticks_per_unit;
                    duration <= cur_cmd.units;
                    tick_now <= cur_cmd.now_val;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        ptt_pkg::resp_t want;
        int             cycle_cnt;
        int             hold_left;
        int             rsp_seen;
        bit             hold_done;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            cycle_cnt = 0;
            hold_left = 0;
            rsp_seen = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_seen++;
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected transaction: result_kind %0d slot %0d", result_kind, slot);
                    errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
                        errors++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, slot);
                        errors++;
                    end
                    if (time_left !== want.time_left)
                    begin
                        $error("time_left: expected %0h, actual %0h", want.time_left, time_left);
                        errors++;
                    end
                    if (running !== want.running)
                    begin
                        $error("running: expected %0d, actual %0d", want.running, running);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        errors++;
                    end
                end
            end
            cycle_cnt++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && rsp_seen >= 120)
            begin
                // one long hold-off so the table backs up onto cmd
                hold_done = 1'b1;
                hold_left = 300;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (cycle_cnt[7:6])
                    2'd0: rsp_stall <= 1'b0;
                    2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n)
            quiet_cycles = 0;
        else if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int                         sel;
        int                         pick;
        bit                         mid_drain_done;
        logic [ptt_pkg::TICK_W-1:0] tpu;
        logic [ptt_pkg::TICK_W-1:0] units;
        logic [ptt_pkg::TICK_W-1:0] step;

        mid_drain_done = 1'b0;

        // directed part
        add_cmd(ptt_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 32'd100);     // baseline only
        add_cmd(ptt_pkg::OP_QUERY, 3'd0, 32'd0, 32'd0, 32'd0);      // free slot
        add_cmd(ptt_pkg::OP_START, 3'd0, 32'd5, 32'd5, 32'd0);      // start on free slot
        add_cmd(ptt_pkg::OP_STOP, 3'd3, 32'd0, 32'd0, 32'd0);       // stop on free slot
        for (int i = 0; i < NTIMERS; i++)
            add_cmd(ptt_pkg::OP_ALLOC, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(ptt_pkg::OP_ALLOC, 3'd0, 32'd0, 32'd0, 32'd0);      // table full
        add_cmd(ptt_pkg::OP_START, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0); // saturates
        add_cmd(ptt_pkg::OP_START, 3'd1, 32'd0, 32'd7, 32'd0);      // zero period
        add_cmd(ptt_pkg::OP_START, 3'd2, 32'd10, 32'd3, 32'd0);
        add_cmd(ptt_pkg::OP_START, 3'd3, 32'd3, 32'd10, 32'd0);
        add_cmd(ptt_pkg::OP_QUERY, 3'd0, 32'd0, 32'd0, 32'd0);
        add_cmd(ptt_pkg::OP_QUERY, 3'd1, 32'd0, 32'd0, 32'd0);
        add_cmd(ptt_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 32'd110);     // no expiry
        add_cmd(ptt_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 32'd140);     // overshoot, two expire
        add_cmd(3'd6, 3'd5, 32'd1, 32'd1, 32'd1);
        add_cmd(3'd7, 3'd2, 32'd1, 32'd1, 32'd1);
        add_cmd(ptt_pkg::OP_FREE, 3'd2, 32'd0, 32'd0, 32'd0);
        add_cmd(ptt_pkg::OP_QUERY, 3'd2, 32'd0, 32'd0, 32'd0);
        add_cmd(ptt_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 32'd5);       // counter wraps
        add_cmd(ptt_pkg::OP_QUERY, 3'd0, 32'd0, 32'd0, 32'd0);
        add_drain();

        // random part
        while (n_items < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (!mid_drain_done && n_items >= 200)
            begin
                mid_drain_done = 1'b1;
                add_drain();
            end
            if (sel < 14)
                add_cmd(ptt_pkg::OP_ALLOC, 3'($urandom), $urandom, $urandom, $urandom);
            else if (sel < 20)
                add_cmd(ptt_pkg::OP_FREE, pick_slot(), $urandom, $urandom, $urandom);
            else if (sel < 44)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    tpu = $urandom_range(1, 8);
                    units = $urandom_range(1, 10);
                end
                else if (pick < 85)
                begin
                    tpu = $urandom;
                    units = $urandom;
                end
                else if (pick < 90)
                begin
                    tpu = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
                    units = (tpu == 0) ? $urandom : 32'd0;
                end
                else
                begin
                    tpu = $urandom;
                    units = 32'd1;
                end
                add_cmd(ptt_pkg::OP_START, pick_slot(), tpu, units, $urandom);
            end
            else if (sel < 50)
                add_cmd(ptt_pkg::OP_STOP, pick_slot(), $urandom, $urandom, $urandom);
            else if (sel < 63)
                add_cmd(ptt_pkg::OP_QUERY, pick_slot(), $urandom, $urandom, $urandom);
            else if (sel < 92)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    step = $urandom_range(1, 40);
                else if (pick < 85)
                    step = $urandom_range(40, 1000);
                else if (pick < 95)
                    step = $urandom;
                else
                    step = 32'd0;
                add_cmd(ptt_pkg::OP_TICK, 3'($urandom), $urandom, $urandom, gen_now + step);
            end
            else if (sel < 96)
            begin
                // same period on every allocated slot, then one tick that expires them together
                step = $urandom_range(1, 30);
                for (int i = 0; i < NTIMERS; i++)
                    if (gen_used[i])
                        add_cmd(ptt_pkg::OP_START, 3'(i), 32'd1, step, $urandom);
                add_cmd(ptt_pkg::OP_TICK, 3'($urandom), $urandom, $urandom, gen_now + step);
            end
            else
                add_cmd(3'($urandom_range(6, 7)), 3'($urandom), $urandom, $urandom, $urandom);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
